FILE: src/bblvr_pkg.sv
// Shared types, constants, arithmetic helpers and the control program of the band-limit core.
package bblvr_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int CHAN_W     = 3;
  localparam int COEF_W     = 32;
  localparam int VOL_W      = 17;
  localparam int PCT_W      = 7;
  localparam int STEP_W     = 17;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam int OPA_W  = 33;
  localparam int OPB_W  = 25;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 60;

  localparam int DIV_SHIFT = 23;
  localparam int NUM_W     = 23;
  localparam int QUO_W     = 23;
  localparam int RECIP_W   = 24;
  localparam int REM_W     = 24;

  localparam int PCT_FULL   = 100;
  localparam int PCT_DIV    = 100;
  localparam int NUM_BIAS   = 50;
  localparam int RECIP_PCT  = (2 ** DIV_SHIFT) / PCT_DIV;
  localparam int RAMP_RESET = 137;

  localparam int FILT_SHIFT = 28;
  localparam int OUT_SHIFT  = 16;
  localparam logic signed [ACC_W-1:0]  FILT_RND = ACC_W'(64'd1 << (FILT_SHIFT - 1));
  localparam logic signed [PROD_W-1:0] OUT_RND  = PROD_W'(64'd1 << (OUT_SHIFT - 1));
  localparam logic signed [ACC_W-1:0]  SAT_MAX  = ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0]  SAT_MIN  = -(ACC_W'(64'sd1 <<< (SAMPLE_W - 1)));

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
  localparam logic [PC_W-1:0] PC_FILT = 5'd11;
  localparam logic [PC_W-1:0] PC_FEND = 5'd19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HPF_GAIN  = 4'd0,
    CFG_HPF_FB1   = 4'd1,
    CFG_HPF_FB2   = 4'd2,
    CFG_LPF_GAIN  = 4'd3,
    CFG_LPF_FB1   = 4'd4,
    CFG_LPF_FB2   = 4'd5,
    CFG_VOL_PCT   = 4'd6,
    CFG_RAMP_STEP = 4'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    A_GAIN,
    A_FB1,
    A_FB2,
    A_RECIP,
    A_DIVISOR,
    A_CVOL,
    A_VOL
  } a_sel_e;

  typedef enum logic [2:0] {
    B_X,
    B_X1,
    B_X2,
    B_Y1,
    B_Y2,
    B_NUM,
    B_QEST,
    B_FRAME
  } b_sel_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_NUM_TGT,
    OP_NUM_PROD,
    OP_Q_LATCH,
    OP_FIX_TGT,
    OP_VOL_UPD,
    OP_FIX_VOL,
    OP_MEM_RD,
    OP_ACC_LOAD,
    OP_ACC_B1,
    OP_ACC_ADD,
    OP_ACC_SUB,
    OP_BIQ_WB,
    OP_OUT
  } op_e;

  typedef enum logic {
    DIV_TGT,
    DIV_FADE
  } div_sel_e;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_WAIT_IN,
    JC_BYPASS,
    JC_STAGE,
    JC_FILT,
    JC_OUT,
    JC_JUMP
  } jc_e;

  typedef struct packed {
    a_sel_e          a_sel;
    b_sel_e          b_sel;
    logic            mul_en;
    op_e             op;
    div_sel_e        div_sel;
    jc_e             jc;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
  } hist_row_t;

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[SAMPLE_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  function automatic ucode_t mk_uc(input a_sel_e a, input b_sel_e b, input logic m,
                                   input op_e o, input div_sel_e d, input jc_e j,
                                   input logic [PC_W-1:0] t);
    ucode_t u;
    u.a_sel   = a;
    u.b_sel   = b;
    u.mul_en  = m;
    u.op      = o;
    u.div_sel = d;
    u.jc      = j;
    u.target  = t;
    return u;
  endfunction

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t u;
    case (pc)
      5'd0:    u = mk_uc(A_GAIN,    B_X,     1'b0, OP_NOP,      DIV_TGT,  JC_WAIT_IN, PC_IDLE);
      5'd1:    u = mk_uc(A_GAIN,    B_X,     1'b0, OP_NUM_TGT,  DIV_TGT,  JC_NEXT,    PC_IDLE);
      5'd2:    u = mk_uc(A_RECIP,   B_NUM,   1'b1, OP_NOP,      DIV_TGT,  JC_NEXT,    PC_IDLE);
      5'd3:    u = mk_uc(A_DIVISOR, B_QEST,  1'b1, OP_Q_LATCH,  DIV_TGT,  JC_NEXT,    PC_IDLE);
      5'd4:    u = mk_uc(A_GAIN,    B_X,     1'b0, OP_FIX_TGT,  DIV_TGT,  JC_NEXT,    PC_IDLE);
      5'd5:    u = mk_uc(A_GAIN,    B_X,     1'b0, OP_VOL_UPD,  DIV_TGT,  JC_NEXT,    PC_IDLE);
      5'd6:    u = mk_uc(A_CVOL,    B_FRAME, 1'b1, OP_NOP,      DIV_FADE, JC_NEXT,    PC_IDLE);
      5'd7:    u = mk_uc(A_GAIN,    B_X,     1'b0, OP_NUM_PROD, DIV_FADE, JC_NEXT,    PC_IDLE);
      5'd8:    u = mk_uc(A_RECIP,   B_NUM,   1'b1, OP_NOP,      DIV_FADE, JC_NEXT,    PC_IDLE);
      5'd9:    u = mk_uc(A_DIVISOR, B_QEST,  1'b1, OP_Q_LATCH,  DIV_FADE, JC_NEXT,    PC_IDLE);
      5'd10:   u = mk_uc(A_GAIN,    B_X,     1'b0, OP_FIX_VOL,  DIV_FADE, JC_NEXT,    PC_IDLE);
      5'd11:   u = mk_uc(A_GAIN,    B_X,     1'b0, OP_MEM_RD,   DIV_TGT,  JC_BYPASS,  PC_FEND);
      5'd12:   u = mk_uc(A_GAIN,    B_X,     1'b1, OP_NOP,      DIV_TGT,  JC_NEXT,    PC_IDLE);
      5'd13:   u = mk_uc(A_GAIN,    B_X1,    1'b1, OP_ACC_LOAD, DIV_TGT,  JC_NEXT,    PC_IDLE);
      5'd14:   u = mk_uc(A_GAIN,    B_X2,    1'b1, OP_ACC_B1,   DIV_TGT,  JC_NEXT,    PC_IDLE);
      5'd15:   u = mk_uc(A_FB1,     B_Y1,    1'b1, OP_ACC_ADD,  DIV_TGT,  JC_NEXT,    PC_IDLE);
      5'd16:   u = mk_uc(A_FB2,     B_Y2,    1'b1, OP_ACC_SUB,  DIV_TGT,  JC_NEXT,    PC_IDLE);
      5'd17:   u = mk_uc(A_GAIN,    B_X,     1'b0, OP_ACC_SUB,  DIV_TGT,  JC_NEXT,    PC_IDLE);
      5'd18:   u = mk_uc(A_GAIN,    B_X,     1'b0, OP_BIQ_WB,   DIV_TGT,  JC_STAGE,   PC_FILT);
      5'd19:   u = mk_uc(A_GAIN,    B_X,     1'b0, OP_NOP,      DIV_TGT,  JC_FILT,    PC_FILT);
      5'd20:   u = mk_uc(A_VOL,     B_X,     1'b1, OP_NOP,      DIV_TGT,  JC_NEXT,    PC_IDLE);
      5'd21:   u = mk_uc(A_GAIN,    B_X,     1'b0, OP_OUT,      DIV_TGT,  JC_OUT,     PC_IDLE);
      default: u = mk_uc(A_GAIN,    B_X,     1'b0, OP_NOP,      DIV_TGT,  JC_JUMP,    PC_IDLE);
    endcase
    return u;
  endfunction

endpackage

FILE: src/bblvr_ifs.sv
// Stream and configuration interfaces of the band-limit core.
interface bblvr_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bblvr_pkg::SAMPLE_W-1:0] sample_in;
  logic        [bblvr_pkg::CHAN_W-1:0]   channel;
  logic                                 buffer_start;
  logic                                 jump_fade;

  modport source (output valid, sample_in, channel, buffer_start, jump_fade, input ready);
  modport sink   (input valid, sample_in, channel, buffer_start, jump_fade, output ready);
endinterface

interface bblvr_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bblvr_pkg::SAMPLE_W-1:0] sample_out;
  logic        [bblvr_pkg::CHAN_W-1:0]   channel_out;

  modport source (output valid, sample_out, channel_out, input ready);
  modport sink   (input valid, sample_out, channel_out, output ready);
endinterface

interface bblvr_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [bblvr_pkg::CFG_IDX_W-1:0]      index;
  logic [bblvr_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/butterworth_band_limit_volume_ramp_core.sv
// Top level of the band-limit and volume-ramp core: microcoded sequencer over one multiplier.
//
//   Channel  Port   Role    Payload
//   sample   in_i   sink    sample_in, channel, buffer_start, jump_fade
//   result   out_o  source  sample_out, channel_out
//   config   cfg_i  sink    index, data
//
// An item runs through the step program, which drives the single shared multiplier with at
// most one product per step; a bypassed filter skips its steps.
// Reset clears the program counter, coefficients, volume percentage, volume state and
// history valid bits, and loads the ramp step with its reset value.
// A result waits in the output register while the next item runs; the last step holds
// only when that register is still full.
module butterworth_band_limit_volume_ramp_core #(
  parameter int MAX_CHANS   = 8,
  parameter int FADE_FRAMES = 50
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  bblvr_sample_if.sink           in_i,
  bblvr_result_if.source         out_o,
  bblvr_cfg_if.sink              cfg_i
);

  localparam int CW         = (MAX_CHANS > 1) ? $clog2(MAX_CHANS) : 1;
  localparam int RW         = CW + 2;
  localparam int HIST_ROWS  = 4 << CW;
  localparam int HALF_ROWS  = HIST_ROWS / 2;
  localparam int FRAME_W    = 6;
  localparam int RECIP_FADE = (2 ** bblvr_pkg::DIV_SHIFT) / FADE_FRAMES;

  localparam int SW  = bblvr_pkg::SAMPLE_W;
  localparam int PW  = bblvr_pkg::PROD_W;
  localparam int AW  = bblvr_pkg::ACC_W;
  localparam int NW  = bblvr_pkg::NUM_W;
  localparam int QW  = bblvr_pkg::QUO_W;
  localparam int VW  = bblvr_pkg::VOL_W;
  localparam int CFW = bblvr_pkg::COEF_W;

  logic [bblvr_pkg::PC_W-1:0] pc_q, pc_d;
  logic                       f_q, f_d;
  logic                       s_q, s_d;
  bblvr_pkg::ucode_t          uc;

  logic signed [CFW-1:0]              hpf_gain_q, hpf_fb1_q, hpf_fb2_q;
  logic signed [CFW-1:0]              lpf_gain_q, lpf_fb1_q, lpf_fb2_q;
  logic [bblvr_pkg::PCT_W-1:0]        vol_pct_q;
  logic [bblvr_pkg::STEP_W-1:0]       ramp_step_q;

  logic [VW-1:0]      cvol_q, cvol_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic               jact_q, jact_d;

  logic signed [SW-1:0]              x_q;
  logic [bblvr_pkg::CHAN_W-1:0]      ch_q;
  logic                              bstart_q;
  logic                              jfade_q;
  logic signed [PW-1:0]              prod_q;
  logic signed [AW-1:0]              acc_q;
  logic [NW-1:0]                     n_q;
  logic [QW-1:0]                     q_q;
  logic [VW-1:0]                     target_q;
  logic [VW-1:0]                     vol_q;

  bblvr_pkg::hist_row_t hist_mem [HIST_ROWS];
  bblvr_pkg::hist_row_t rd_q;
  logic                 rd_valid_q;
  logic [HIST_ROWS-1:0] valid_q;

  logic                 out_valid_q, out_valid_d;
  logic signed [SW-1:0] sample_out_q;
  logic [bblvr_pkg::CHAN_W-1:0] channel_out_q;

  logic in_acc, cfg_acc, out_free, do_out, ch_ok, bypass;
  logic clr_hpf, clr_lpf;
  logic [RW-1:0] row_idx;
  logic [CW-1:0] chan_idx;
  logic signed [CFW-1:0] gain_sel, fb1_sel, fb2_sel;
  logic signed [SW-1:0]  hx1, hx2, hy1, hy2;
  logic signed [bblvr_pkg::OPA_W-1:0] a_op;
  logic signed [bblvr_pkg::OPB_W-1:0] b_op;
  logic [bblvr_pkg::RECIP_W-1:0] recip_sel;
  logic [bblvr_pkg::REM_W-1:0]   divisor_sel, rem;
  logic [QW-1:0]                 q_est, q_fix;
  logic [bblvr_pkg::PCT_W-1:0]   pct_clamp;
  logic [NW-1:0]                 num_tgt;
  logic signed [AW-1:0]          prod_ext, filt_sum;
  logic signed [PW-1:0]          out_sum;
  logic signed [SW-1:0]          filt_y, out_y;
  logic [VW:0]                   vol_up;
  logic                          fade_on;

  assign uc       = bblvr_pkg::ucode_rom(pc_q);
  assign in_i.ready  = (pc_q == bblvr_pkg::PC_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc   = in_i.valid && in_i.ready;
  assign cfg_acc  = cfg_i.valid && cfg_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign do_out   = (uc.jc == bblvr_pkg::JC_OUT) && out_free;

  assign out_o.valid       = out_valid_q;
  assign out_o.sample_out  = sample_out_q;
  assign out_o.channel_out = channel_out_q;

  assign ch_ok    = 32'(ch_q) < 32'(MAX_CHANS);
  assign chan_idx = CW'(ch_q);
  assign row_idx  = {f_q, s_q, chan_idx};
  assign gain_sel = f_q ? lpf_gain_q : hpf_gain_q;
  assign fb1_sel  = f_q ? lpf_fb1_q : hpf_fb1_q;
  assign fb2_sel  = f_q ? lpf_fb2_q : hpf_fb2_q;
  assign bypass   = (gain_sel == '0) || !ch_ok;

  assign hx1 = rd_valid_q ? rd_q.x1 : '0;
  assign hx2 = rd_valid_q ? rd_q.x2 : '0;
  assign hy1 = rd_valid_q ? rd_q.y1 : '0;
  assign hy2 = rd_valid_q ? rd_q.y2 : '0;

  assign recip_sel   = (uc.div_sel == bblvr_pkg::DIV_TGT) ?
                       bblvr_pkg::RECIP_W'(bblvr_pkg::RECIP_PCT) :
                       bblvr_pkg::RECIP_W'(RECIP_FADE);
  assign divisor_sel = (uc.div_sel == bblvr_pkg::DIV_TGT) ?
                       bblvr_pkg::REM_W'(bblvr_pkg::PCT_DIV) :
                       bblvr_pkg::REM_W'(FADE_FRAMES);
  assign q_est = prod_q[bblvr_pkg::DIV_SHIFT+QW-1:bblvr_pkg::DIV_SHIFT];
  assign rem   = bblvr_pkg::REM_W'(n_q) - prod_q[bblvr_pkg::REM_W-1:0];
  assign q_fix = q_q + QW'(rem >= divisor_sel);

  assign pct_clamp = (vol_pct_q > bblvr_pkg::PCT_W'(bblvr_pkg::PCT_FULL)) ?
                     bblvr_pkg::PCT_W'(bblvr_pkg::PCT_FULL) : vol_pct_q;
  assign num_tgt   = {pct_clamp, 16'b0} + NW'(bblvr_pkg::NUM_BIAS);

  assign prod_ext = AW'(prod_q);
  assign filt_sum = acc_q + bblvr_pkg::FILT_RND;
  assign filt_y   = bblvr_pkg::sat24(filt_sum >>> bblvr_pkg::FILT_SHIFT);
  assign out_sum  = prod_q + bblvr_pkg::OUT_RND;
  assign out_y    = bblvr_pkg::sat24(AW'(out_sum >>> bblvr_pkg::OUT_SHIFT));
  assign fade_on  = jact_q && (frame_q < FRAME_W'(FADE_FRAMES));

  always_comb begin
    unique case (uc.a_sel)
      bblvr_pkg::A_GAIN:    a_op = bblvr_pkg::OPA_W'(gain_sel);
      bblvr_pkg::A_FB1:     a_op = bblvr_pkg::OPA_W'(fb1_sel);
      bblvr_pkg::A_FB2:     a_op = bblvr_pkg::OPA_W'(fb2_sel);
      bblvr_pkg::A_RECIP:   a_op = signed'(bblvr_pkg::OPA_W'(recip_sel));
      bblvr_pkg::A_DIVISOR: a_op = signed'(bblvr_pkg::OPA_W'(divisor_sel));
      bblvr_pkg::A_CVOL:    a_op = signed'(bblvr_pkg::OPA_W'(cvol_q));
      bblvr_pkg::A_VOL:     a_op = signed'(bblvr_pkg::OPA_W'(vol_q));
      default:              a_op = '0;
    endcase
  end

  always_comb begin
    unique case (uc.b_sel)
      bblvr_pkg::B_X:     b_op = bblvr_pkg::OPB_W'(x_q);
      bblvr_pkg::B_X1:    b_op = bblvr_pkg::OPB_W'(hx1);
      bblvr_pkg::B_X2:    b_op = bblvr_pkg::OPB_W'(hx2);
      bblvr_pkg::B_Y1:    b_op = bblvr_pkg::OPB_W'(hy1);
      bblvr_pkg::B_Y2:    b_op = bblvr_pkg::OPB_W'(hy2);
      bblvr_pkg::B_NUM:   b_op = signed'(bblvr_pkg::OPB_W'(n_q));
      bblvr_pkg::B_QEST:  b_op = signed'(bblvr_pkg::OPB_W'(q_est));
      bblvr_pkg::B_FRAME: b_op = signed'(bblvr_pkg::OPB_W'(frame_q));
      default:            b_op = '0;
    endcase
  end

  always_comb begin
    pc_d = pc_q + 1'b1;
    f_d  = f_q;
    s_d  = s_q;
    unique case (uc.jc)
      bblvr_pkg::JC_NEXT: begin
        pc_d = pc_q + 1'b1;
      end
      bblvr_pkg::JC_WAIT_IN: begin
        pc_d = in_acc ? pc_q + 1'b1 : pc_q;
        if (in_acc) begin
          f_d = 1'b0;
          s_d = 1'b0;
        end
      end
      bblvr_pkg::JC_BYPASS: begin
        pc_d = bypass ? uc.target : pc_q + 1'b1;
      end
      bblvr_pkg::JC_STAGE: begin
        if (!s_q) begin
          s_d  = 1'b1;
          pc_d = uc.target;
        end
      end
      bblvr_pkg::JC_FILT: begin
        s_d = 1'b0;
        if (!f_q) begin
          f_d  = 1'b1;
          pc_d = uc.target;
        end
      end
      bblvr_pkg::JC_OUT: begin
        pc_d = out_free ? uc.target : pc_q;
      end
      bblvr_pkg::JC_JUMP: begin
        pc_d = uc.target;
      end
      default: begin
        pc_d = bblvr_pkg::PC_IDLE;
      end
    endcase
  end

  always_comb begin
    cvol_d  = cvol_q;
    frame_d = frame_q;
    jact_d  = jact_q;
    vol_up  = (VW + 1)'(cvol_q) + (VW + 1)'(ramp_step_q);
    if (ch_q == '0) begin
      if (cvol_q < target_q) begin
        cvol_d = (vol_up > (VW + 1)'(target_q)) ? target_q : vol_up[VW-1:0];
      end else if (cvol_q > target_q) begin
        cvol_d = ((cvol_q - target_q) > ramp_step_q) ? cvol_q - ramp_step_q : target_q;
      end
      if (!bstart_q && (frame_q < FRAME_W'(FADE_FRAMES))) begin
        frame_d = frame_q + 1'b1;
      end
    end
    if (bstart_q) begin
      frame_d = '0;
      jact_d  = jfade_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (do_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    clr_hpf = 1'b0;
    clr_lpf = 1'b0;
    if (cfg_acc) begin
      unique case (bblvr_pkg::cfg_idx_e'(cfg_i.index))
        bblvr_pkg::CFG_HPF_GAIN, bblvr_pkg::CFG_HPF_FB1, bblvr_pkg::CFG_HPF_FB2: begin
          clr_hpf = 1'b1;
        end
        bblvr_pkg::CFG_LPF_GAIN, bblvr_pkg::CFG_LPF_FB1, bblvr_pkg::CFG_LPF_FB2: begin
          clr_lpf = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= bblvr_pkg::PC_IDLE;
      f_q         <= 1'b0;
      s_q         <= 1'b0;
      out_valid_q <= 1'b0;
      hpf_gain_q  <= '0;
      hpf_fb1_q   <= '0;
      hpf_fb2_q   <= '0;
      lpf_gain_q  <= '0;
      lpf_fb1_q   <= '0;
      lpf_fb2_q   <= '0;
      vol_pct_q   <= '0;
      ramp_step_q <= bblvr_pkg::STEP_W'(bblvr_pkg::RAMP_RESET);
      cvol_q      <= '0;
      frame_q     <= '0;
      jact_q      <= 1'b0;
      valid_q     <= '0;
    end else begin
      pc_q        <= pc_d;
      f_q         <= f_d;
      s_q         <= s_d;
      out_valid_q <= out_valid_d;
      if (uc.op == bblvr_pkg::OP_VOL_UPD) begin
        cvol_q  <= cvol_d;
        frame_q <= frame_d;
        jact_q  <= jact_d;
      end
      if (uc.op == bblvr_pkg::OP_BIQ_WB) begin
        valid_q[row_idx] <= 1'b1;
      end
      if (clr_hpf) begin
        valid_q[HALF_ROWS-1:0] <= '0;
      end
      if (clr_lpf) begin
        valid_q[HIST_ROWS-1:HALF_ROWS] <= '0;
      end
      if (cfg_acc) begin
        unique case (bblvr_pkg::cfg_idx_e'(cfg_i.index))
          bblvr_pkg::CFG_HPF_GAIN:  hpf_gain_q  <= cfg_i.data;
          bblvr_pkg::CFG_HPF_FB1:   hpf_fb1_q   <= cfg_i.data;
          bblvr_pkg::CFG_HPF_FB2:   hpf_fb2_q   <= cfg_i.data;
          bblvr_pkg::CFG_LPF_GAIN:  lpf_gain_q  <= cfg_i.data;
          bblvr_pkg::CFG_LPF_FB1:   lpf_fb1_q   <= cfg_i.data;
          bblvr_pkg::CFG_LPF_FB2:   lpf_fb2_q   <= cfg_i.data;
          bblvr_pkg::CFG_VOL_PCT:   vol_pct_q   <= cfg_i.data[bblvr_pkg::PCT_W-1:0];
          bblvr_pkg::CFG_RAMP_STEP: ramp_step_q <= cfg_i.data[bblvr_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (uc.op == bblvr_pkg::OP_MEM_RD) begin
      rd_q       <= hist_mem[row_idx];
      rd_valid_q <= valid_q[row_idx];
    end
    if (uc.op == bblvr_pkg::OP_BIQ_WB) begin
      hist_mem[row_idx] <= '{x1: x_q, x2: hx1, y1: filt_y, y2: hy1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q      <= in_i.sample_in;
      ch_q     <= in_i.channel;
      bstart_q <= in_i.buffer_start;
      jfade_q  <= in_i.jump_fade;
    end
    if (uc.mul_en) begin
      prod_q <= a_op * b_op;
    end
    unique case (uc.op)
      bblvr_pkg::OP_NUM_TGT:  n_q      <= num_tgt;
      bblvr_pkg::OP_NUM_PROD: n_q      <= prod_q[NW-1:0];
      bblvr_pkg::OP_Q_LATCH:  q_q      <= q_est;
      bblvr_pkg::OP_FIX_TGT:  target_q <= q_fix[VW-1:0];
      bblvr_pkg::OP_FIX_VOL:  vol_q    <= fade_on ? q_fix[VW-1:0] : cvol_q;
      bblvr_pkg::OP_ACC_LOAD: acc_q    <= prod_ext;
      bblvr_pkg::OP_ACC_B1:   acc_q    <= f_q ? acc_q + (prod_ext <<< 1)
                                              : acc_q - (prod_ext <<< 1);
      bblvr_pkg::OP_ACC_ADD:  acc_q    <= acc_q + prod_ext;
      bblvr_pkg::OP_ACC_SUB:  acc_q    <= acc_q - prod_ext;
      bblvr_pkg::OP_BIQ_WB:   x_q      <= filt_y;
      bblvr_pkg::OP_OUT: begin
        if (do_out) begin
          sample_out_q  <= out_y;
          channel_out_q <= ch_q;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: sim/tb_top.sv
// Testbench for the band-limit and volume-ramp core: a directed table, then random streams checked by a behavioral predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bblvr_pkg::*;

  localparam int CHANS       = 8;
  localparam int FADE_LEN    = 50;
  localparam int HPF         = 0;
  localparam int LPF         = 1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 100;
  localparam int N_DIR       = 16;

  typedef logic signed [SAMPLE_W-1:0] smp_t;

  typedef struct {
    smp_t               sample;
    logic [CHAN_W-1:0]  chan;
  } due_t;

  typedef struct {
    smp_t               x;
    logic [CHAN_W-1:0]  ch;
    bit                 bs;
    bit                 jf;
    bit                 known;
    smp_t               want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  bblvr_sample_if sample_bus ();
  bblvr_result_if result_bus ();
  bblvr_cfg_if    cfg_bus ();

  butterworth_band_limit_volume_ramp_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (sample_bus),
    .out_o  (result_bus),
    .cfg_i  (cfg_bus)
  );

  logic signed [COEF_W-1:0] coef_gain [2];
  logic signed [COEF_W-1:0] coef_fb1 [2];
  logic signed [COEF_W-1:0] coef_fb2 [2];
  logic [PCT_W-1:0]         vol_pct;
  logic [STEP_W-1:0]        ramp_inc;
  smp_t                     hx1 [2][2*CHANS];
  smp_t                     hx2 [2][2*CHANS];
  smp_t                     hy1 [2][2*CHANS];
  smp_t                     hy2 [2][2*CHANS];
  int unsigned              cur_vol;
  int unsigned              frame_cnt;
  bit                       fade_on;

  due_t     due_samples [$];
  dir_row_t dir_rows [N_DIR];
  int       mismatch_count;
  int       sender_idle_pct;
  int       recv_stall_pct;
  int       cycle_count;

  function automatic smp_t clip24(longint v);
    smp_t r;
    if (v > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  function automatic void clear_history(int f);
    for (int i = 0; i < 2*CHANS; i++) begin
      hx1[f][i] = '0;
      hx2[f][i] = '0;
      hy1[f][i] = '0;
      hy2[f][i] = '0;
    end
  endfunction

  function automatic smp_t biquad(int f, int slot, smp_t x);
    longint g;
    longint b1;
    longint acc;
    smp_t   y;
    g   = coef_gain[f];
    b1  = (f == HPF) ? -2 * g : 2 * g;
    acc = g * x + b1 * hx1[f][slot] + g * hx2[f][slot]
          - longint'(coef_fb1[f]) * hy1[f][slot] - longint'(coef_fb2[f]) * hy2[f][slot];
    y = clip24((acc + (64'sd1 <<< 27)) >>> 28);
    hx2[f][slot] = hx1[f][slot];
    hx1[f][slot] = x;
    hy2[f][slot] = hy1[f][slot];
    hy1[f][slot] = y;
    return y;
  endfunction

  function automatic smp_t filter_and_scale(smp_t x_in, logic [CHAN_W-1:0] ch, bit bs, bit jf);
    int unsigned pct;
    int unsigned target;
    int unsigned n;
    int unsigned v;
    smp_t        x;
    longint      prod;
    x = x_in;
    if (ch == 0) begin
      pct    = (vol_pct > PCT_FULL) ? PCT_FULL : vol_pct;
      target = (pct * 65536 + 50) / 100;
      if (cur_vol < target) begin
        n       = cur_vol + ramp_inc;
        cur_vol = (n > target) ? target : n;
      end else if (cur_vol > target) begin
        cur_vol = ((cur_vol - target) > ramp_inc) ? cur_vol - ramp_inc : target;
      end
      if (!bs && frame_cnt < FADE_LEN) begin
        frame_cnt++;
      end
    end
    if (bs) begin
      frame_cnt = 0;
      fade_on   = jf;
    end
    if (coef_gain[HPF] != 0) begin
      for (int s = 0; s < 2; s++) begin
        x = biquad(HPF, s * CHANS + ch, x);
      end
    end
    if (coef_gain[LPF] != 0) begin
      for (int s = 0; s < 2; s++) begin
        x = biquad(LPF, s * CHANS + ch, x);
      end
    end
    v = cur_vol;
    if (fade_on && frame_cnt < FADE_LEN) begin
      v = (cur_vol * frame_cnt) / FADE_LEN;
    end
    prod = longint'(x) * longint'(v);
    return clip24((prod + 64'sd32768) >>> 16);
  endfunction

  function automatic void load_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_HPF_GAIN: begin
        coef_gain[HPF] = val;
        clear_history(HPF);
      end
      CFG_HPF_FB1: begin
        coef_fb1[HPF] = val;
        clear_history(HPF);
      end
      CFG_HPF_FB2: begin
        coef_fb2[HPF] = val;
        clear_history(HPF);
      end
      CFG_LPF_GAIN: begin
        coef_gain[LPF] = val;
        clear_history(LPF);
      end
      CFG_LPF_FB1: begin
        coef_fb1[LPF] = val;
        clear_history(LPF);
      end
      CFG_LPF_FB2: begin
        coef_fb2[LPF] = val;
        clear_history(LPF);
      end
      CFG_VOL_PCT: begin
        vol_pct = val[PCT_W-1:0];
      end
      CFG_RAMP_STEP: begin
        ramp_inc = val[STEP_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  function automatic smp_t pick_sample();
    smp_t r;
    case ($urandom_range(9))
      0: r = 24'sh7FFFFF;
      1: r = 24'sh800000;
      2: r = smp_t'(int'($urandom_range(511)) - 256);
      default: r = smp_t'($urandom);
    endcase
    return r;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    load_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] hg, hf1, hf2, lg, lf1, lf2,
                              input logic [CFG_DATA_W-1:0] pct, step);
    write_reg(CFG_HPF_GAIN, hg);
    write_reg(CFG_HPF_FB1, hf1);
    write_reg(CFG_HPF_FB2, hf2);
    write_reg(CFG_LPF_GAIN, lg);
    write_reg(CFG_LPF_FB1, lf1);
    write_reg(CFG_LPF_FB2, lf2);
    write_reg(CFG_VOL_PCT, pct);
    write_reg(CFG_RAMP_STEP, step);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_sample(smp_t x, logic [CHAN_W-1:0] ch, bit bs, bit jf, bit known,
                             smp_t want);
    due_t d;
    while ($urandom_range(99) < sender_idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    sample_bus.valid        <= 1'b1;
    sample_bus.sample_in    <= x;
    sample_bus.channel      <= ch;
    sample_bus.buffer_start <= bs;
    sample_bus.jump_fade    <= jf;
    @(posedge clk_i);
    while (!sample_bus.ready) @(posedge clk_i);
    d.sample = filter_and_scale(x, ch, bs, jf);
    if (known) begin
      d.sample = want;
    end
    d.chan = ch;
    due_samples.push_back(d);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    while (due_samples.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_stream(int n_items, int width, int idle, int stall, bit hold_mid);
    int                nch;
    int                sent;
    logic [CHAN_W-1:0] ch;
    bit                bs;
    bit                jf;
    sender_idle_pct = idle;
    recv_stall_pct  = stall;
    nch  = (width == 0) ? $urandom_range(1, CHANS) : width;
    sent = 0;
    while (sent < n_items) begin
      for (int c = 0; c < nch && sent < n_items; c++) begin
        ch = c;
        bs = (c == 0) && ($urandom_range(79) == 0);
        jf = ($urandom_range(3) != 0);
        case ($urandom_range(199))
          0: bs = 1'b1;
          1, 2, 3, 4, 5, 6, 7, 8: ch = $urandom_range(CHANS - 1);
          9: begin
            ch = $urandom_range(CHANS - 1);
            bs = 1'b1;
          end
          default: begin
          end
        endcase
        if (hold_mid && sent == n_items / 2) begin
          sample_bus.valid <= 1'b0;
          drain_results();
        end
        send_sample(pick_sample(), ch, bs, jf, 1'b0, '0);
        sent++;
      end
    end
    sample_bus.valid <= 1'b0;
    drain_results();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    due_t got;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (due_samples.size() == 0) begin
        $error("unexpected result: sample_out %0d channel_out %0d",
               result_bus.sample_out, result_bus.channel_out);
        mismatch_count++;
      end else begin
        got = due_samples.pop_front();
        if (got.sample !== result_bus.sample_out) begin
          $error("sample_out: expected %0d, actual %0d", got.sample, result_bus.sample_out);
          mismatch_count++;
        end
        if (got.chan !== result_bus.channel_out) begin
          $error("channel_out: expected %0d, actual %0d", got.chan, result_bus.channel_out);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_ni                  = 1'b0;
    sample_bus.valid        = 1'b0;
    sample_bus.sample_in    = '0;
    sample_bus.channel      = '0;
    sample_bus.buffer_start = 1'b0;
    sample_bus.jump_fade    = 1'b0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.index           = '0;
    cfg_bus.data            = '0;
    mismatch_count          = 0;
    sender_idle_pct         = 0;
    recv_stall_pct          = 0;
    for (int f = 0; f < 2; f++) begin
      coef_gain[f] = '0;
      coef_fb1[f]  = '0;
      coef_fb2[f]  = '0;
      clear_history(f);
    end
    vol_pct   = '0;
    ramp_inc  = STEP_W'(RAMP_RESET);
    cur_vol   = 0;
    frame_cnt = 0;
    fade_on   = 1'b0;

    // With full volume reached in one step and both filters bypassed, the output equals the
    // input; a jump buffer start forces the fade to zero.
    dir_rows = '{
      '{24'sd1234,      3'd1, 1'b0, 1'b0, 1'b1, 24'sd0},
      '{24'sh7FFFFF,    3'd0, 1'b0, 1'b0, 1'b1, 24'sh7FFFFF},
      '{24'sh800000,    3'd7, 1'b0, 1'b0, 1'b1, 24'sh800000},
      '{24'sd0,         3'd3, 1'b0, 1'b0, 1'b1, 24'sd0},
      '{-24'sd1,        3'd0, 1'b0, 1'b0, 1'b1, -24'sd1},
      '{24'sd1,         3'd5, 1'b0, 1'b0, 1'b1, 24'sd1},
      '{24'sd100000,    3'd2, 1'b1, 1'b1, 1'b1, 24'sd0},
      '{24'sh7FFFFF,    3'd0, 1'b0, 1'b0, 1'b0, 24'sd0},
      '{24'sh800000,    3'd1, 1'b0, 1'b0, 1'b0, 24'sd0},
      '{24'sd5000,      3'd0, 1'b1, 1'b1, 1'b1, 24'sd0},
      '{24'sh400000,    3'd0, 1'b0, 1'b0, 1'b0, 24'sd0},
      '{24'sh400000,    3'd0, 1'b1, 1'b0, 1'b1, 24'sh400000},
      '{-24'sd4194304,  3'd4, 1'b1, 1'b0, 1'b1, -24'sd4194304},
      '{24'sh2AAAAA,    3'd6, 1'b0, 1'b0, 1'b1, 24'sh2AAAAA},
      '{24'sh555555,    3'd0, 1'b0, 1'b0, 1'b1, 24'sh555555},
      '{24'sd123456,    3'd0, 1'b1, 1'b1, 1'b1, 24'sd0}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    program_regs(0, 0, 0, 0, 0, 0, 100, 65536);
    for (int i = 0; i < N_DIR; i++) begin
      send_sample(dir_rows[i].x, dir_rows[i].ch, dir_rows[i].bs, dir_rows[i].jf,
                  dir_rows[i].known, dir_rows[i].want);
    end
    sample_bus.valid <= 1'b0;
    drain_results();

    program_regs(262529877, -524943000, 256700000, 18119393, -306821726, 110810157, 80, 1000);
    run_stream(170, 1, 0, 0, 1'b1);

    program_regs(262529877, -524943000, 256700000, 0, -306821726, 110810157, 127, 2000);
    run_stream(140, 0, 74, 0, 1'b0);

    program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 100, 0);
    run_stream(130, 0, 8, 8, 1'b0);

    program_regs(0, -524943000, 256700000, 18119393, -306821726, 110810157, 30, 131071);
    run_stream(120, 2, 0, 74, 1'b0);

    program_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom_range(127), $urandom_range(131071));
    run_stream(140, 0, 0, 0, 1'b0);

    program_regs(262529877, -524943000, 256700000, 18119393, -306821726, 110810157, 0, 300);
    run_stream(120, 1, 8, 8, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
